FILE: hdl/wcmc_pkg.sv
package wcmc_pkg;

	// message geometry
	localparam int MAX_MESSAGE_BYTES = 64;
	localparam int LEN_LIMIT         = MAX_MESSAGE_BYTES - 4;
	localparam int LEN_W             = 6;
	localparam int POS_W             = 7;
	localparam logic [POS_W-1:0] POS_LIMIT = '1;

	// crc-32, msb first, non-reflected
	localparam logic [31:0] CRC_POLY = 32'h04C1_1DB7;
	localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;

	// configuration register map
	localparam int APB_ADDR_W = 3;
	localparam int APB_DATA_W = 32;
	localparam logic [APB_ADDR_W-1:0] ADDR_PAYLOAD_LENGTH = 3'd0;

	typedef logic [LEN_W-1:0] len_t;
	typedef logic [POS_W-1:0] pos_t;
	typedef logic [31:0][31:0] crc_cols_t;

	// response of 32 shift steps to a single set bit, worked out at elaboration
	function automatic logic [31:0] crc_shift32(input logic [31:0] c_in);
		logic [31:0] c;
		c = c_in;
		for (int k = 0; k < 32; k++) begin
			if (c[31]) begin
				c = (c << 1) ^ CRC_POLY;
			end else begin
				c = c << 1;
			end
		end
		return c;
	endfunction

	function automatic crc_cols_t build_crc_cols();
		crc_cols_t cols;
		for (int i = 0; i < 32; i++) begin
			cols[i] = crc_shift32(32'(1) << i);
		end
		return cols;
	endfunction

	localparam crc_cols_t CRC_COLS = build_crc_cols();

	// one-word crc update as a flat xor network over the constant columns
	function automatic logic [31:0] crc_word(input logic [31:0] crc, input logic [31:0] word);
		logic [31:0] c;
		logic [31:0] acc;
		c   = crc ^ word;
		acc = '0;
		for (int i = 0; i < 32; i++) begin
			acc = acc ^ (CRC_COLS[i] & {32{c[i]}});
		end
		return acc;
	endfunction

endpackage

FILE: hdl/wcmc_msg_if.sv
interface wcmc_msg_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       start_message;

	modport source (output valid, output data_byte, output start_message, input ready);
	modport sink (input valid, input data_byte, input start_message, output ready);
endinterface

FILE: hdl/wcmc_result_if.sv
interface wcmc_result_if;
	logic        valid;
	logic        ready;
	logic        crc_ok;
	logic [31:0] computed_crc;
	logic [31:0] received_crc;

	modport source (output valid, output crc_ok, output computed_crc, output received_crc,
		input ready);
	modport sink (input valid, input crc_ok, input computed_crc, input received_crc,
		output ready);
endinterface

FILE: hdl/wordwise_crc32_message_check_top.sv
// channel   dir   payload                                     handshake
// msg       in    data_byte[7:0], start_message               valid/ready
// result    out   crc_ok, computed_crc[31:0], received_crc    valid/ready
// apb       in    payload_length at byte address 0            psel/penable, pready = 1
//
// one byte per cycle while msg is not stalled; a byte is held in the input register,
// then the crc xor network and message state update it from there.
// a result is loaded into the result register as the fourth footer byte leaves the input register.
// arst_n clears the message state and sets payload_length to 60.
// msg stalls only when a result is due while the previous result is still held.
module wordwise_crc32_message_check_top
	import wcmc_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	wcmc_msg_if.sink              msg,
	wcmc_result_if.source         result,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [APB_ADDR_W-1:0] paddr,
	input  logic [APB_DATA_W-1:0] pwdata,
	output logic [APB_DATA_W-1:0] prdata,
	output logic                  pready
);

	len_t        len_reg_q;
	logic        valid_s1;
	logic [7:0]  data_s1;
	logic        start_s1;
	logic [31:0] crc_q;
	logic [23:0] pending_q;
	pos_t        pos_q;
	logic [31:0] footer_q;
	logic        out_valid_q;
	logic        out_ok_q;
	logic [31:0] out_computed_q;
	logic [31:0] out_received_q;

	len_t        len_eff;
	logic [31:0] crc_base;
	logic [23:0] pending_base;
	pos_t        pos_base;
	logic [31:0] footer_base;
	logic [31:0] crc_next;
	logic [23:0] pending_next;
	logic [31:0] footer_next;
	pos_t        pos_next;
	logic [7:0]  pos_wide;
	logic [7:0]  len_wide;
	logic [1:0]  lane;
	logic [1:0]  footer_idx;
	logic        produce;
	logic        stall;
	logic        advance;
	logic        cfg_write;

	// apb register port
	assign pready    = 1'b1;
	assign cfg_write = psel && penable && pwrite && pready && (paddr == ADDR_PAYLOAD_LENGTH);
	assign prdata    = (paddr == ADDR_PAYLOAD_LENGTH) ? APB_DATA_W'(len_reg_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_reg_q <= LEN_W'(LEN_LIMIT);
		end else if (cfg_write) begin
			len_reg_q <= pwdata[LEN_W-1:0];
		end
	end

	// clamp the length to the message capacity
	always_comb begin
		if (32'(len_reg_q) > LEN_LIMIT) begin
			len_eff = LEN_W'(LEN_LIMIT);
		end else begin
			len_eff = len_reg_q;
		end
	end

	// message state as seen by the registered byte, after an optional restart
	always_comb begin
		if (start_s1) begin
			crc_base     = CRC_INIT;
			pending_base = '0;
			pos_base     = '0;
			footer_base  = '0;
		end else begin
			crc_base     = crc_q;
			pending_base = pending_q;
			pos_base     = pos_q;
			footer_base  = footer_q;
		end
	end

	// per-byte update: payload packing, word crc, footer gathering
	always_comb begin
		pos_wide     = 8'(pos_base);
		len_wide     = 8'(len_eff);
		lane         = pos_base[1:0];
		footer_idx   = 2'(pos_wide - len_wide);
		crc_next     = crc_base;
		pending_next = pending_base;
		footer_next  = footer_base;
		produce      = 1'b0;
		if (pos_wide < len_wide) begin
			if (lane == 2'd3) begin
				crc_next     = crc_word(crc_base, {data_s1, pending_base});
				pending_next = '0;
			end else begin
				pending_next = pending_base | 24'({16'b0, data_s1} << (8 * lane));
			end
		end else if (pos_wide < len_wide + 8'd4) begin
			if (footer_idx == 2'd0) begin
				if (len_eff[1:0] != 2'd0) begin
					crc_next = crc_word(crc_base, {8'b0, pending_base});
				end
				pending_next = '0;
				footer_next  = {24'b0, data_s1};
			end else begin
				footer_next = footer_base | ({24'b0, data_s1} << (8 * footer_idx));
			end
			produce = (footer_idx == 2'd3);
		end
		pos_next = (pos_base < POS_LIMIT) ? pos_base + 1'b1 : pos_base;
	end

	// flow control between input register and result register
	assign stall     = valid_s1 && produce && out_valid_q && !result.ready;
	assign advance   = valid_s1 && !stall;
	assign msg.ready = !valid_s1 || !stall;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (msg.ready) begin
			valid_s1 <= msg.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (msg.ready && msg.valid) begin
			data_s1  <= msg.data_byte;
			start_s1 <= msg.start_message;
		end
	end

	// message state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_q     <= CRC_INIT;
			pending_q <= '0;
			pos_q     <= '0;
			footer_q  <= '0;
		end else if (advance) begin
			crc_q     <= crc_next;
			pending_q <= pending_next;
			pos_q     <= pos_next;
			footer_q  <= footer_next;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && produce) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && produce) begin
			out_ok_q       <= (footer_next == crc_next);
			out_computed_q <= crc_next;
			out_received_q <= footer_next;
		end
	end

	assign result.valid        = out_valid_q;
	assign result.crc_ok       = out_ok_q;
	assign result.computed_crc = out_computed_q;
	assign result.received_crc = out_received_q;

endmodule

FILE: dv/wcmc_checker.sv
module wcmc_checker
	import wcmc_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	wcmc_msg_if                   msg,
	wcmc_result_if                result,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [APB_ADDR_W-1:0] paddr,
	input  logic [APB_DATA_W-1:0] pwdata,
	input  logic                  pready,
	output int                    mismatches,
	output int                    expected_left
);

	localparam len_t LENGTH_AT_RESET = 60;

	typedef struct packed {
		logic        crc_ok;
		logic [31:0] computed_crc;
		logic [31:0] received_crc;
	} crc_verdict_t;

	// own copy of the register and the message state
	len_t        payload_length;
	logic [31:0] crc_acc;
	logic [23:0] partial_word;
	pos_t        msg_pos;
	logic [31:0] footer_acc;

	// verdicts still owed by the block, oldest first
	crc_verdict_t verdict_q [$];

	// one whole-word crc step, msb first
	function automatic logic [31:0] crc_after_word(input logic [31:0] crc,
		input logic [31:0] word);
		logic [31:0] c;
		c = crc ^ word;
		for (int b = 0; b < 32; b++) begin
			c = c[31] ? ((c << 1) ^ CRC_POLY) : (c << 1);
		end
		return c;
	endfunction

	task automatic restart_message();
		crc_acc      = CRC_INIT;
		partial_word = '0;
		msg_pos      = '0;
		footer_acc   = '0;
	endtask

	always @(posedge clk or negedge arst_n) begin : model_step
		crc_verdict_t due;
		int eff_len;
		int pos;
		int k;
		if (!arst_n) begin
			payload_length = LENGTH_AT_RESET;
			restart_message();
			verdict_q.delete();
			mismatches = 0;
		end else begin
			// retire the oldest verdict against each delivered result
			if (result.valid && result.ready) begin
				if (verdict_q.size() == 0) begin
					$error("result with nothing pending: crc_ok %0b computed_crc %h received_crc %h",
						result.crc_ok, result.computed_crc, result.received_crc);
					mismatches++;
				end else begin
					due = verdict_q.pop_front();
					if (result.crc_ok !== due.crc_ok) begin
						$error("crc_ok: expected %0b, actual %0b", due.crc_ok, result.crc_ok);
						mismatches++;
					end
					if (result.computed_crc !== due.computed_crc) begin
						$error("computed_crc: expected %h, actual %h",
							due.computed_crc, result.computed_crc);
						mismatches++;
					end
					if (result.received_crc !== due.received_crc) begin
						$error("received_crc: expected %h, actual %h",
							due.received_crc, result.received_crc);
						mismatches++;
					end
				end
			end

			// advance the message state on each accepted item
			if (msg.valid && msg.ready) begin
				eff_len = (payload_length > LEN_LIMIT) ? LEN_LIMIT : payload_length;
				if (msg.start_message) begin
					restart_message();
				end
				pos = msg_pos;
				if (pos < eff_len) begin
					// payload: pack little-endian, fold in on the top lane
					if (pos % 4 == 3) begin
						crc_acc      = crc_after_word(crc_acc, {msg.data_byte, partial_word});
						partial_word = '0;
					end else begin
						partial_word = partial_word | (24'(msg.data_byte) << (8 * (pos % 4)));
					end
				end else if (pos < eff_len + 4) begin
					// footer: flush a partial word first, then gather the received crc
					k = pos - eff_len;
					if (k == 0) begin
						if (eff_len % 4 != 0) begin
							crc_acc = crc_after_word(crc_acc, {8'h00, partial_word});
						end
						partial_word = '0;
						footer_acc   = '0;
					end
					footer_acc = footer_acc | (32'(msg.data_byte) << (8 * k));
					if (k == 3) begin
						due.crc_ok       = (footer_acc == crc_acc);
						due.computed_crc = crc_acc;
						due.received_crc = footer_acc;
						verdict_q.push_back(due);
					end
				end
				if (msg_pos != POS_LIMIT) begin
					msg_pos = msg_pos + 1'b1;
				end
			end

			// follow register writes
			if (psel && penable && pwrite && pready && paddr == ADDR_PAYLOAD_LENGTH) begin
				payload_length = pwdata[LEN_W-1:0];
			end
		end
		expected_left <= verdict_q.size();
	end

endmodule

FILE: dv/tb_top.sv
module tb_top;
	import wcmc_pkg::*;

	localparam int CYCLE_LIMIT  = 200000;
	localparam int DRAIN_CYCLES = 8;
	localparam int LONG_HOLD    = 400;
	localparam int PHASE_ITEMS  = 115;
	localparam int PHASES       = 12;

	typedef enum int {
		MSG_GOOD,
		MSG_BAD_CRC,
		MSG_TRAILING,
		MSG_CUT_SHORT
	} frame_kind_t;

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  psel;
	logic                  penable;
	logic                  pwrite;
	logic [APB_ADDR_W-1:0] paddr;
	logic [APB_DATA_W-1:0] pwdata;
	logic [APB_DATA_W-1:0] prdata;
	logic                  pready;

	int mismatches;
	int expected_left;
	int cycle_count = 0;

	// idling knobs, in percent per item or per cycle
	int gap_pct;
	int stall_pct;
	bit long_hold_req = 1'b0;

	// message under construction
	logic [7:0] frame [0:127];
	int         frame_len;

	wcmc_msg_if    msg_ch ();
	wcmc_result_if res_ch ();

	wordwise_crc32_message_check_top uut (
		.clk     (clk),
		.arst_n  (arst_n),
		.msg     (msg_ch),
		.result  (res_ch),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	wcmc_checker chk (
		.clk           (clk),
		.arst_n        (arst_n),
		.msg           (msg_ch),
		.result        (res_ch),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.pready        (pready),
		.mismatches    (mismatches),
		.expected_left (expected_left)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// run limit
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("tb_top: FAIL");
			$finish;
		end
	end

	// result side: random stall bursts plus one long hold-off on request
	initial begin : result_sink
		int stall_left;
		stall_left = 0;
		res_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (stall_left > 0) begin
				stall_left--;
				res_ch.ready <= 1'b0;
			end else if (long_hold_req) begin
				long_hold_req = 1'b0;
				stall_left    = LONG_HOLD - 1;
				res_ch.ready <= 1'b0;
			end else if (stall_pct > 0 && $urandom_range(0, 99) < stall_pct) begin
				stall_left    = $urandom_range(0, 10);
				res_ch.ready <= 1'b0;
			end else begin
				res_ch.ready <= 1'b1;
			end
		end
	end

	// crc of the first n frame bytes, as the footer of a good message carries it
	function automatic logic [31:0] frame_crc(input int n);
		logic [31:0] acc;
		logic [31:0] word;
		acc = CRC_INIT;
		for (int i = 0; i < n; i += 4) begin
			word = '0;
			for (int j = 0; j < 4; j++) begin
				if (i + j < n) begin
					word[8*j +: 8] = frame[i + j];
				end
			end
			acc = acc ^ word;
			for (int b = 0; b < 32; b++) begin
				acc = acc[31] ? ((acc << 1) ^ CRC_POLY) : (acc << 1);
			end
		end
		return acc;
	endfunction

	// one item, after an optional idle burst
	task automatic send_byte(input logic [7:0] b, input logic first);
		if (gap_pct > 0 && $urandom_range(0, 99) < gap_pct) begin
			msg_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 11)) @(posedge clk);
		end
		msg_ch.valid         <= 1'b1;
		msg_ch.data_byte     <= b;
		msg_ch.start_message <= first;
		do @(posedge clk); while (!msg_ch.ready);
	endtask

	task automatic send_frame(input bit with_start, input int from_idx, input int to_idx);
		for (int i = from_idx; i < to_idx; i++) begin
			send_byte(frame[i], with_start && i == 0);
		end
	endtask

	// append the footer to an n-byte payload, then shape the frame by kind
	task automatic seal_frame(input int n, input frame_kind_t kind);
		logic [31:0] footer;
		int          extra;
		footer = frame_crc(n);
		if (kind == MSG_BAD_CRC) begin
			if ($urandom_range(0, 1)) begin
				footer = footer ^ (32'h1 << $urandom_range(0, 31));
			end else begin
				footer = $urandom;
			end
		end
		for (int k = 0; k < 4; k++) begin
			frame[n + k] = footer[8*k +: 8];
		end
		frame_len = n + 4;
		if (kind == MSG_TRAILING) begin
			extra = $urandom_range(1, 8);
			for (int k = 0; k < extra; k++) begin
				frame[frame_len + k] = $urandom;
			end
			frame_len += extra;
		end else if (kind == MSG_CUT_SHORT) begin
			frame_len = $urandom_range(1, n + 3);
		end
	endtask

	// drop valid, wait for every verdict, then let the pipeline drain
	task automatic settle();
		msg_ch.valid <= 1'b0;
		@(posedge clk);
		while (expected_left != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// register write with setup and access phases, only once the block is quiet
	task automatic set_length(input int len);
		settle();
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= ADDR_PAYLOAD_LENGTH;
		pwdata  <= ($urandom & ~32'h3F) | 32'(len);
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	// messages of mostly good shape with random content, some broken
	task automatic random_phase(input int len, input int budget);
		int          n;
		int          sent;
		int          pick;
		frame_kind_t kind;
		n    = (len > LEN_LIMIT) ? LEN_LIMIT : len;
		sent = 0;
		while (sent < budget) begin
			pick = $urandom_range(0, 99);
			if (pick < 70) begin
				kind = MSG_GOOD;
			end else if (pick < 82) begin
				kind = MSG_BAD_CRC;
			end else if (pick < 92) begin
				kind = MSG_TRAILING;
			end else begin
				kind = MSG_CUT_SHORT;
			end
			for (int i = 0; i < n; i++) begin
				frame[i] = $urandom;
			end
			seal_frame(n, kind);
			send_frame($urandom_range(0, 19) != 0, 0, frame_len);
			sent += frame_len;
		end
	endtask

	initial begin : stimulus
		int phase_len [PHASES];
		msg_ch.valid         <= 1'b0;
		msg_ch.data_byte     <= 8'h00;
		msg_ch.start_message <= 1'b0;
		psel                 <= 1'b0;
		penable              <= 1'b0;
		pwrite               <= 1'b0;
		paddr                <= ADDR_PAYLOAD_LENGTH;
		pwdata               <= '0;
		arst_n               <= 1'b0;
		gap_pct   = 20;
		stall_pct = 20;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		// first message without any start flag, extreme byte values
		set_length(2);
		frame[0] = 8'h00;
		frame[1] = 8'hFF;
		seal_frame(2, MSG_GOOD);
		send_frame(1'b0, 0, frame_len);

		// one full word plus a partial word, wrong footer
		set_length(5);
		frame[0] = 8'hFF;
		frame[1] = 8'hFF;
		frame[2] = 8'hFF;
		frame[3] = 8'hFF;
		frame[4] = 8'h00;
		seal_frame(5, MSG_BAD_CRC);
		send_frame(1'b1, 0, frame_len);

		// length shortened in the middle of a message
		set_length(7);
		for (int i = 0; i < 3; i++) begin
			frame[i] = $urandom;
		end
		seal_frame(3, MSG_GOOD);
		send_frame(1'b1, 0, 3);
		set_length(3);
		send_frame(1'b1, 3, frame_len);

		// empty payload, then position saturation: no wrap back to a new footer
		set_length(0);
		seal_frame(0, MSG_GOOD);
		send_frame(1'b1, 0, frame_len);
		for (int i = 0; i < 124; i++) begin
			send_byte($urandom, 1'b0);
		end
		send_frame(1'b0, 0, frame_len);

		// random phases over a spread of lengths, extremes included
		phase_len = '{1, 4, 60, 0, 7, 63, 3, 13, 2, 61, 5, 8};
		for (int i = 0; i < PHASES; i++) begin
			if (i >= PHASES - 2) begin
				phase_len[i] = $urandom_range(0, 63);
			end
			set_length(phase_len[i]);
			if (i == PHASES - 1 || i % 3 == 2) begin
				gap_pct   = 0;
				stall_pct = 0;
			end else begin
				gap_pct   = $urandom_range(5, 40);
				stall_pct = $urandom_range(5, 40);
			end
			// short messages and a long result stall fill the block up
			if (phase_len[i] == 0 && i < PHASES - 2) begin
				long_hold_req = 1'b1;
			end
			random_phase(phase_len[i], PHASE_ITEMS);
		end

		settle();
		if (mismatches == 0) begin
			$display("tb_top: PASS");
		end else begin
			$display("tb_top: FAIL");
		end
		$finish;
	end

endmodule
